### hw/rtl/assert_macros.svh
// Assertion macros shared by the fraction reduction RTL.
// No dependencies; included inside module bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### hw/rtl/frm_pkg.sv
// Types and constants for the fraction reduction block.
// No dependencies; used by frm_div and fraction_reduce_mixed.
package frm_pkg;

    localparam int WIDTH_DEF = 16;
    localparam int OUT_W     = 16;

    localparam logic [1:0] FORM_INTEGER = 2'd0;
    localparam logic [1:0] FORM_PROPER  = 2'd1;
    localparam logic [1:0] FORM_MIXED   = 2'd2;

    localparam logic ST_OK       = 1'b0;
    localparam logic ST_ZERO_DEN = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GCD,
        S_RN,
        S_RD,
        S_WH,
        S_DONE
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

### hw/rtl/frm_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on frm_pkg and assert_macros.svh.
module frm_div #(
    parameter int WIDTH = frm_pkg::WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_dividend,
    input  logic [WIDTH-1:0] i_divisor,
    output frm_pkg::t_div_stat o_stat,
    output logic [WIDTH-1:0] o_quotient,
    output logic [WIDTH-1:0] o_remainder
);
    import frm_pkg::*;

    localparam int CNT_W = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] r_rem, n_rem;
    logic [WIDTH-1:0] r_quo, n_quo;
    logic [WIDTH-1:0] r_dvs, n_dvs;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [WIDTH:0]   w_shift;
    logic [WIDTH:0]   w_diff;
    logic             w_fits;

    assign w_shift = {r_rem, r_quo[WIDTH-1]};
    assign w_diff  = w_shift - {1'b0, r_dvs};
    assign w_fits  = !w_diff[WIDTH];

    always_comb begin
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dvs  = i_divisor;
            n_cnt  = CNT_W'(WIDTH);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem = w_fits ? w_diff[WIDTH-1:0] : w_shift[WIDTH-1:0];
            n_quo = {r_quo[WIDTH-2:0], w_fits};
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_stat.busy  = r_busy;
    assign o_stat.done  = r_done;
    assign o_quotient   = r_quo;
    assign o_remainder  = r_rem;

    `include "assert_macros.svh"

    `ASSERT_IMPLY(a_div_nonzero, i_clk, i_rst_n, r_busy, r_dvs != '0)
    `ASSERT_NEXT(a_div_start, i_clk, i_rst_n, i_start, r_busy && !r_done)
    `ASSERT_IMPLY(a_rem_below, i_clk, i_rst_n, r_done, r_rem < r_dvs)

endmodule

### hw/rtl/fraction_reduce_mixed.sv
// Fraction reduction to lowest terms and mixed-number form.
// Depends on frm_pkg, frm_div and assert_macros.svh.
//
// One request at a time. Every division, first Euclid's remainder loop and then
// n/g, d/g and the whole/remainder split, runs on the single bit-serial divider.
// A request with k Euclid steps runs k + 3 divisions; k is at most about 24 at
// 16 bits. A zero denominator skips the divider and finishes with status set
// and all else zero. The result sits in an output register, so the next request
// may start while it waits to be taken. Outputs are the low 16 bits of the
// reduced values.
module fraction_reduce_mixed #(
    parameter int WIDTH = frm_pkg::WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [WIDTH-1:0]          i_numerator,
    input  logic [WIDTH-1:0]          i_denominator,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [frm_pkg::OUT_W-1:0] o_reduced_numerator,
    output logic [frm_pkg::OUT_W-1:0] o_reduced_denominator,
    output logic [frm_pkg::OUT_W-1:0] o_whole_part,
    output logic [frm_pkg::OUT_W-1:0] o_remainder_numerator,
    output logic [1:0]                o_form_code,
    output logic                      o_status
);
    import frm_pkg::*;

    t_state           r_state, n_state;
    logic             r_go, n_go;
    logic             r_err, n_err;
    logic [WIDTH-1:0] r_n, n_n;
    logic [WIDTH-1:0] r_d, n_d;
    logic [WIDTH-1:0] r_x, n_x;
    logic [WIDTH-1:0] r_y, n_y;
    logic [WIDTH-1:0] r_rn, n_rn;
    logic [WIDTH-1:0] r_rd, n_rd;
    logic [WIDTH-1:0] r_wh, n_wh;
    logic [WIDTH-1:0] r_rm, n_rm;

    logic             r_ovalid, n_ovalid;
    logic [OUT_W-1:0] r_o_rn, n_o_rn;
    logic [OUT_W-1:0] r_o_rd, n_o_rd;
    logic [OUT_W-1:0] r_o_wh, n_o_wh;
    logic [OUT_W-1:0] r_o_rm, n_o_rm;
    logic [1:0]       r_o_form, n_o_form;
    logic             r_o_st, n_o_st;

    logic             w_accept;
    logic             w_load;
    logic [WIDTH-1:0] w_dvd;
    logic [WIDTH-1:0] w_dvs;
    logic [WIDTH-1:0] w_quo;
    logic [WIDTH-1:0] w_rem;
    t_div_stat        w_div;
    logic [1:0]       w_form;
    logic             w_div_phase;
    logic             w_out_zero;

    frm_div #(
        .WIDTH(WIDTH)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (r_go),
        .i_dividend  (w_dvd),
        .i_divisor   (w_dvs),
        .o_stat      (w_div),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    assign w_accept = i_valid && !o_stall;
    assign w_load   = (r_state == S_DONE) && (!r_ovalid || !i_stall);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = (i_denominator == '0) ? S_DONE : S_GCD;
                end
            end
            S_GCD: begin
                if (w_div.done && w_rem == '0) begin
                    n_state = S_RN;
                end
            end
            S_RN: begin
                if (w_div.done) n_state = S_RD;
            end
            S_RD: begin
                if (w_div.done) n_state = S_WH;
            end
            S_WH: begin
                if (w_div.done) n_state = S_DONE;
            end
            S_DONE: begin
                if (w_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs and divider control
    always_comb begin
        o_stall = (r_state != S_IDLE);
        n_go    = 1'b0;
        w_dvd   = r_x;
        w_dvs   = r_y;
        case (r_state)
            S_IDLE: n_go = w_accept && (i_denominator != '0);
            S_GCD:  n_go = w_div.done;
            S_RN: begin
                w_dvd = r_n;
                n_go  = w_div.done;
            end
            S_RD: begin
                w_dvd = r_d;
                n_go  = w_div.done;
            end
            S_WH: begin
                w_dvd = r_rn;
                w_dvs = r_rd;
            end
            default: n_go = 1'b0;
        endcase
    end

    always_comb begin
        if (r_rd == WIDTH'(1)) begin
            w_form = FORM_INTEGER;
        end else if (r_rn < r_rd) begin
            w_form = FORM_PROPER;
        end else begin
            w_form = FORM_MIXED;
        end
    end

    // datapath
    always_comb begin
        n_n      = r_n;
        n_d      = r_d;
        n_x      = r_x;
        n_y      = r_y;
        n_rn     = r_rn;
        n_rd     = r_rd;
        n_wh     = r_wh;
        n_rm     = r_rm;
        n_err    = r_err;
        n_ovalid = r_ovalid && i_stall;
        n_o_rn   = r_o_rn;
        n_o_rd   = r_o_rd;
        n_o_wh   = r_o_wh;
        n_o_rm   = r_o_rm;
        n_o_form = r_o_form;
        n_o_st   = r_o_st;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_n   = i_numerator;
                    n_d   = i_denominator;
                    n_x   = i_numerator;
                    n_y   = i_denominator;
                    n_err = (i_denominator == '0);
                end
            end
            S_GCD: begin
                if (w_div.done && w_rem != '0) begin
                    n_x = r_y;
                    n_y = w_rem;
                end
            end
            S_RN: begin
                if (w_div.done) n_rn = w_quo;
            end
            S_RD: begin
                if (w_div.done) n_rd = w_quo;
            end
            S_WH: begin
                if (w_div.done) begin
                    n_wh = w_quo;
                    n_rm = w_rem;
                end
            end
            S_DONE: begin
                if (w_load) begin
                    n_ovalid = 1'b1;
                    if (r_err) begin
                        n_o_rn   = '0;
                        n_o_rd   = '0;
                        n_o_wh   = '0;
                        n_o_rm   = '0;
                        n_o_form = FORM_INTEGER;
                        n_o_st   = ST_ZERO_DEN;
                    end else begin
                        n_o_rn   = OUT_W'(r_rn);
                        n_o_rd   = OUT_W'(r_rd);
                        n_o_wh   = OUT_W'(r_wh);
                        n_o_rm   = OUT_W'(r_rm);
                        n_o_form = w_form;
                        n_o_st   = ST_OK;
                    end
                end
            end
            default: n_err = r_err;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_go     <= 1'b0;
            r_ovalid <= 1'b0;
            r_err    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_go     <= n_go;
            r_ovalid <= n_ovalid;
            r_err    <= n_err;
        end
        r_n      <= n_n;
        r_d      <= n_d;
        r_x      <= n_x;
        r_y      <= n_y;
        r_rn     <= n_rn;
        r_rd     <= n_rd;
        r_wh     <= n_wh;
        r_rm     <= n_rm;
        r_o_rn   <= n_o_rn;
        r_o_rd   <= n_o_rd;
        r_o_wh   <= n_o_wh;
        r_o_rm   <= n_o_rm;
        r_o_form <= n_o_form;
        r_o_st   <= n_o_st;
    end

    assign o_valid               = r_ovalid;
    assign o_reduced_numerator   = r_o_rn;
    assign o_reduced_denominator = r_o_rd;
    assign o_whole_part          = r_o_wh;
    assign o_remainder_numerator = r_o_rm;
    assign o_form_code           = r_o_form;
    assign o_status              = r_o_st;

    assign w_div_phase = r_state inside {S_GCD, S_RN, S_RD, S_WH};
    assign w_out_zero  = ({r_o_rn, r_o_rd, r_o_wh, r_o_rm} == '0);

    `include "assert_macros.svh"

    `ASSERT_IMPLY(a_done_in_div_state, i_clk, i_rst_n, w_div.done, w_div_phase)
    `ASSERT_IMPLY(a_err_zeroes, i_clk, i_rst_n, r_ovalid && r_o_st == ST_ZERO_DEN, w_out_zero)
    `ASSERT_NEXT(a_go_not_idle, i_clk, i_rst_n, r_go, r_state != S_IDLE && w_div.busy)

endmodule

### tb/tb_fraction_reduce_mixed.sv
// Self-checking testbench for fraction_reduce_mixed: lowest terms and mixed-number form.
// Depends on frm_pkg and the fraction_reduce_mixed RTL; a scoreboard class predicts
// each reply from the accepted request and checks the replies in order.
module tb_fraction_reduce_mixed;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM    = 1330;
    localparam int HOLD_OFF    = 500;
    localparam int IDLE_LIMIT  = 5000;
    localparam int SETTLE      = 600;
    localparam int HOLD_AFTER  = 300;

    localparam bit [31:0] DIRECTED [0:20] = '{
        {16'd0, 16'd0}, {16'd0, 16'd5}, {16'd5, 16'd0}, {16'd65535, 16'd0},
        {16'd0, 16'd65535}, {16'd65535, 16'd65535}, {16'd65535, 16'd1},
        {16'd1, 16'd65535}, {16'd1, 16'd1}, {16'd12, 16'd8}, {16'd3, 16'd4},
        {16'd8, 16'd4}, {16'd6, 16'd9}, {16'd46368, 16'd28657},
        {16'd28657, 16'd46368}, {16'd65521, 16'd65519}, {16'd32768, 16'd16384},
        {16'hAAAA, 16'h5555}, {16'h5555, 16'hAAAA}, {16'd7, 16'd1},
        {16'd65534, 16'd65535}
    };

    typedef struct packed {
        logic [frm_pkg::OUT_W-1:0] rn;
        logic [frm_pkg::OUT_W-1:0] rd;
        logic [frm_pkg::OUT_W-1:0] whole;
        logic [frm_pkg::OUT_W-1:0] rem;
        logic [1:0]                form;
        logic                      status;
    } t_fraction;

    class t_fraction_board;
        t_fraction pending[$];
        int requests, replies, errors;
        int zero_dens, zero_nums, integers, propers, mixeds;

        function t_fraction reduce_fraction(logic [15:0] n, logic [15:0] d);
            t_fraction r;
            int unsigned a, b, t, g;
            r = '0;
            if (d == 0) begin
                r.status = frm_pkg::ST_ZERO_DEN;
                return r;
            end
            a = 32'(n);
            b = 32'(d);
            while (b != 0) begin
                t = a % b;
                a = b;
                b = t;
            end
            g = (n == 0) ? 32'(d) : a;
            r.rn = 16'(32'(n) / g);
            r.rd = 16'(32'(d) / g);
            r.whole = r.rn / r.rd;
            r.rem = r.rn % r.rd;
            if (r.rd == 1)
                r.form = frm_pkg::FORM_INTEGER;
            else if (r.rn < r.rd)
                r.form = frm_pkg::FORM_PROPER;
            else
                r.form = frm_pkg::FORM_MIXED;
            r.status = frm_pkg::ST_OK;
            return r;
        endfunction

        function void note_request(logic [15:0] n, logic [15:0] d);
            t_fraction r;
            r = reduce_fraction(n, d);
            pending.push_back(r);
            requests++;
            if (r.status == frm_pkg::ST_ZERO_DEN)
                zero_dens++;
            else begin
                if (n == 0)
                    zero_nums++;
                case (r.form)
                    frm_pkg::FORM_INTEGER: integers++;
                    frm_pkg::FORM_PROPER:  propers++;
                    default:               mixeds++;
                endcase
            end
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: reply %0d %s expected %0d got %0d",
                         $time, replies, name, want, got);
                errors++;
            end
        endfunction

        function void check_reply(t_fraction got);
            t_fraction want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected reply, expected none got %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            compare_field("reduced_numerator", want.rn, got.rn);
            compare_field("reduced_denominator", want.rd, got.rd);
            compare_field("whole_part", want.whole, got.whole);
            compare_field("remainder_numerator", want.rem, got.rem);
            compare_field("form_code", want.form, got.form);
            compare_field("status", want.status, got.status);
            replies++;
        endfunction
    endclass

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_stall;
    logic [15:0]               i_numerator;
    logic [15:0]               i_denominator;
    logic                      o_valid;
    logic                      i_stall;
    logic [frm_pkg::OUT_W-1:0] o_reduced_numerator;
    logic [frm_pkg::OUT_W-1:0] o_reduced_denominator;
    logic [frm_pkg::OUT_W-1:0] o_whole_part;
    logic [frm_pkg::OUT_W-1:0] o_remainder_numerator;
    logic [1:0]                o_form_code;
    logic                      o_status;

    t_fraction_board board = new;
    int  idle_cycles = 0;
    int  burst_left = 0;
    bit  draining = 0;

    fraction_reduce_mixed #(.WIDTH(16)) dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_stall              (o_stall),
        .i_numerator          (i_numerator),
        .i_denominator        (i_denominator),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_reduced_numerator  (o_reduced_numerator),
        .o_reduced_denominator(o_reduced_denominator),
        .o_whole_part         (o_whole_part),
        .o_remainder_numerator(o_remainder_numerator),
        .o_form_code          (o_form_code),
        .o_status             (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // handshake monitor: values seen here are those the block sampled at the edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                board.note_request(i_numerator, i_denominator);
            if (o_valid && !i_stall)
                board.check_reply({o_reduced_numerator, o_reduced_denominator, o_whole_part,
                                   o_remainder_numerator, o_form_code, o_status});
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
        end
    end

    initial begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("%0t: no request moved for %0d cycles", $time, IDLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    // receiver stalls, with one long hold-off once traffic is flowing
    initial begin
        int  mode;
        int  mode_left;
        bit  held_off;
        logic stall;
        mode = 0;
        mode_left = 0;
        held_off = 0;
        while (!draining) begin
            if (!held_off && board.requests >= HOLD_AFTER) begin
                held_off = 1;
                i_stall <= 1'b1;
                repeat (HOLD_OFF) @(posedge i_clk);
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(10, 80);
                end
                mode_left--;
                case (mode)
                    0:       stall = 1'b0;
                    1:       stall = 1'($urandom_range(0, 1));
                    default: stall = ($urandom_range(0, 3) != 0);
                endcase
                i_stall <= stall;
                @(posedge i_clk);
            end
        end
        i_stall <= 1'b0;
    end

    task automatic send_request(input logic [15:0] n, input logic [15:0] d);
        int gap;
        i_valid <= 1'b1;
        i_numerator <= n;
        i_denominator <= d;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 12);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
    endtask

    function automatic bit [31:0] random_fraction();
        logic [15:0] n, d, g;
        n = 16'($urandom);
        d = 16'($urandom);
        case ($urandom_range(0, 9))
            3: begin
                g = 16'($urandom_range(1, 255));
                n = 16'(32'(g) * $urandom_range(0, 255));
                d = 16'(32'(g) * $urandom_range(1, 255));
            end
            4: begin
                n = 16'($urandom_range(0, 20));
                d = 16'($urandom_range(0, 20));
            end
            5: begin
                d = 16'($urandom_range(1, 255));
                n = 16'(32'(d) * $urandom_range(0, 255));
            end
            6: d = 16'($urandom_range(1, 15));
            7: if ($urandom_range(0, 1)) n = '0; else d = '0;
            8: begin
                d = 16'($urandom_range(1, 65535));
                n = 16'($urandom_range(0, 32'(d) - 1));
            end
            default: ;
        endcase
        return {n, d};
    endfunction

    initial begin
        bit [31:0] pair;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_numerator <= '0;
        i_denominator <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED[k])
            send_request(DIRECTED[k][31:16], DIRECTED[k][15:0]);
        repeat (N_RANDOM) begin
            pair = random_fraction();
            send_request(pair[31:16], pair[15:0]);
        end
        i_valid <= 1'b0;

        while (board.pending.size() != 0) @(posedge i_clk);
        draining = 1;
        repeat (SETTLE) @(posedge i_clk);

        $display("%0d requests, %0d replies checked, %0d mismatches", board.requests,
                 board.replies, board.errors);
        $display("zero denominators %0d, zero numerators %0d, integer %0d, proper %0d, mixed %0d",
                 board.zero_dens, board.zero_nums, board.integers, board.propers,
                 board.mixeds);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/frm_pkg.sv
hw/rtl/frm_div.sv
hw/rtl/fraction_reduce_mixed.sv
tb/tb_fraction_reduce_mixed.sv
